/* design/sgr_pkg.sv */
// sgr_pkg: shared types, codes and the plain sgr code decode function
// for the sgr attribute decoder; no dependencies
`timescale 1ns / 1ps

package sgr_pkg;

    localparam int PARAM_BITS_DEF = 16;
    localparam int PARAM_BITS_MAX = 32;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [7:0] DEFAULT_COLOUR = 8'd255;

    localparam logic [31:0] CODE_RESET     = 32'd0;
    localparam logic [31:0] CODE_BOLD      = 32'd1;
    localparam logic [31:0] CODE_DIM       = 32'd2;
    localparam logic [31:0] CODE_UNDERLINE = 32'd4;
    localparam logic [31:0] CODE_INVERSE   = 32'd7;
    localparam logic [31:0] CODE_NORMAL    = 32'd22;
    localparam logic [31:0] CODE_NO_UL     = 32'd24;
    localparam logic [31:0] CODE_NO_INV    = 32'd27;
    localparam logic [31:0] CODE_FG_DEF    = 32'd39;
    localparam logic [31:0] CODE_BG_DEF    = 32'd49;
    localparam logic [31:0] CODE_FG_EXT    = 32'd38;
    localparam logic [31:0] CODE_BG_EXT    = 32'd48;
    localparam logic [31:0] CODE_EXT_IDX   = 32'd5;
    localparam logic [31:0] CODE_EXT_RGB   = 32'd2;
    localparam logic [31:0] FG_BASE        = 32'd30;
    localparam logic [31:0] BG_BASE        = 32'd40;
    localparam logic [31:0] FG_BRIGHT_BASE = 32'd90;
    localparam logic [31:0] BG_BRIGHT_BASE = 32'd100;
    localparam logic [31:0] BRIGHT_OFFSET  = 32'd8;
    localparam logic [31:0] RANGE_SPAN     = 32'd7;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_OPEN  = 3'd1;
    localparam logic [2:0] PH_IDX   = 3'd2;
    localparam logic [2:0] PH_RGB_R = 3'd3;
    localparam logic [2:0] PH_RGB_G = 3'd4;
    localparam logic [2:0] PH_RGB_B = 3'd5;

    typedef struct packed {
        logic [7:0] background;
        logic [7:0] foreground;
        logic       inverse;
        logic       underline;
        logic       dim;
        logic       bold;
    } pen_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       target_fg;
    } ctrl_t;

    function automatic pen_t decode_plain(pen_t pen, logic [31:0] v);
        pen_t        r;
        logic [31:0] d;
        r = pen;
        d = 32'd0;
        priority if (v == CODE_RESET)
        begin
            r.bold       = 1'b0;
            r.dim        = 1'b0;
            r.underline  = 1'b0;
            r.inverse    = 1'b0;
            r.foreground = DEFAULT_COLOUR;
            r.background = DEFAULT_COLOUR;
        end
        else if (v == CODE_BOLD)
        begin
            r.bold = 1'b1;
        end
        else if (v == CODE_DIM)
        begin
            r.dim = 1'b1;
        end
        else if (v == CODE_UNDERLINE)
        begin
            r.underline = 1'b1;
        end
        else if (v == CODE_INVERSE)
        begin
            r.inverse = 1'b1;
        end
        else if (v == CODE_NORMAL)
        begin
            r.bold = 1'b0;
            r.dim  = 1'b0;
        end
        else if (v == CODE_NO_UL)
        begin
            r.underline = 1'b0;
        end
        else if (v == CODE_NO_INV)
        begin
            r.inverse = 1'b0;
        end
        else if (v == CODE_FG_DEF)
        begin
            r.foreground = DEFAULT_COLOUR;
        end
        else if (v == CODE_BG_DEF)
        begin
            r.background = DEFAULT_COLOUR;
        end
        else if (v >= FG_BASE && v <= FG_BASE + RANGE_SPAN)
        begin
            d = v - FG_BASE;
            r.foreground = d[7:0];
        end
        else if (v >= BG_BASE && v <= BG_BASE + RANGE_SPAN)
        begin
            d = v - BG_BASE;
            r.background = d[7:0];
        end
        else if (v >= FG_BRIGHT_BASE && v <= FG_BRIGHT_BASE + RANGE_SPAN)
        begin
            d = v - FG_BRIGHT_BASE + BRIGHT_OFFSET;
            r.foreground = d[7:0];
        end
        else if (v >= BG_BRIGHT_BASE && v <= BG_BRIGHT_BASE + RANGE_SPAN)
        begin
            d = v - BG_BRIGHT_BASE + BRIGHT_OFFSET;
            r.background = d[7:0];
        end
        else
        begin
            r = pen;
        end
        return r;
    endfunction

endpackage

/* design/sgr_decode.sv */
// sgr_decode: next pen, run state and held value load for one parameter
// depends on sgr_pkg
`timescale 1ns / 1ps

module sgr_decode #(
    parameter int PARAM_BITS = sgr_pkg::PARAM_BITS_DEF
) (
    input  sgr_pkg::pen_t           pen,
    input  sgr_pkg::ctrl_t          ctrl,
    input  logic [PARAM_BITS-1:0]   param,
    input  logic                    last,
    input  logic [PARAM_BITS-1:0]   held,
    output sgr_pkg::pen_t           pen_next,
    output sgr_pkg::ctrl_t          ctrl_next,
    output logic                    held_load
);

    logic [31:0]   v;
    logic [31:0]   hv;
    sgr_pkg::pen_t replay_pen;

    assign v  = 32'(param);
    assign hv = 32'(held);

    always_comb
    begin
        pen_next        = pen;
        ctrl_next       = ctrl;
        ctrl_next.phase = sgr_pkg::PH_IDLE;
        held_load       = 1'b0;
        replay_pen      = sgr_pkg::decode_plain(pen, sgr_pkg::CODE_EXT_RGB);
        unique case (ctrl.phase)
            sgr_pkg::PH_OPEN:
            begin
                if (v == sgr_pkg::CODE_EXT_IDX && !last)
                begin
                    ctrl_next.phase = sgr_pkg::PH_IDX;
                end
                else if (v == sgr_pkg::CODE_EXT_RGB && !last)
                begin
                    ctrl_next.phase = sgr_pkg::PH_RGB_R;
                end
                else if (!last && (v == sgr_pkg::CODE_FG_EXT || v == sgr_pkg::CODE_BG_EXT))
                begin
                    ctrl_next.target_fg = (v == sgr_pkg::CODE_FG_EXT);
                    ctrl_next.phase     = sgr_pkg::PH_OPEN;
                end
                else
                begin
                    pen_next = sgr_pkg::decode_plain(pen, v);
                end
            end
            sgr_pkg::PH_IDX:
            begin
                if (ctrl.target_fg)
                begin
                    pen_next.foreground = {4'd0, v[3:0]};
                end
                else
                begin
                    pen_next.background = {4'd0, v[3:0]};
                end
            end
            sgr_pkg::PH_RGB_R:
            begin
                if (last)
                begin
                    pen_next = sgr_pkg::decode_plain(replay_pen, v);
                end
                else
                begin
                    held_load       = 1'b1;
                    ctrl_next.phase = sgr_pkg::PH_RGB_G;
                end
            end
            sgr_pkg::PH_RGB_G:
            begin
                if (last)
                begin
                    pen_next = sgr_pkg::decode_plain(
                        sgr_pkg::decode_plain(replay_pen, hv), v);
                end
                else
                begin
                    ctrl_next.phase = sgr_pkg::PH_RGB_B;
                end
            end
            sgr_pkg::PH_RGB_B:
            begin
                ctrl_next.phase = sgr_pkg::PH_IDLE;
            end
            default:
            begin
                if (!last && (v == sgr_pkg::CODE_FG_EXT || v == sgr_pkg::CODE_BG_EXT))
                begin
                    ctrl_next.target_fg = (v == sgr_pkg::CODE_FG_EXT);
                    ctrl_next.phase     = sgr_pkg::PH_OPEN;
                end
                else
                begin
                    pen_next = sgr_pkg::decode_plain(pen, v);
                end
            end
        endcase
    end

endmodule

/* design/sgr_attribute_decoder_top.sv */
// sgr_attribute_decoder_top: input register, decode, pen state, result register
// depends on sgr_pkg and sgr_decode
// a last parameter is held in the input register, then its pen is registered onto m_tdata
// one parameter per cycle unless stalled, set by the single decode stage and pen register
// a waiting result only stalls the input register when it holds another last item
// reset: asynchronous active low, pen bold/dim/underline/inverse clear, colours 255
// no extended colour run pending and both stages empty after reset
`timescale 1ns / 1ps

module sgr_attribute_decoder_top #(
    parameter int PARAM_BITS = sgr_pkg::PARAM_BITS_DEF,
    localparam int IN_W      = ((PARAM_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // param
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sgr_pkg::OUT_TDATA_W-1:0] m_tdata  // bold, dim, underline, inverse,
                                                     // foreground, background
);

    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic [PARAM_BITS-1:0] s1_param_reg;
    logic [PARAM_BITS-1:0] held_reg;
    logic                  out_valid_reg;
    sgr_pkg::pen_t         out_pen_reg;
    sgr_pkg::pen_t         pen_reg;
    sgr_pkg::pen_t         pen_next;
    sgr_pkg::ctrl_t        ctrl_reg;
    sgr_pkg::ctrl_t        ctrl_next;
    logic                  held_load;
    logic                  s1_fire;
    logic                  in_fire;

    assign s1_fire  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_pen_reg};

    sgr_decode #(
        .PARAM_BITS (PARAM_BITS)
    ) u_decode (
        .pen       (pen_reg),
        .ctrl      (ctrl_reg),
        .param     (s1_param_reg),
        .last      (s1_last_reg),
        .held      (held_reg),
        .pen_next  (pen_next),
        .ctrl_next (ctrl_next),
        .held_load (held_load)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            s1_last_reg          <= 1'b0;
            out_valid_reg        <= 1'b0;
            pen_reg.bold         <= 1'b0;
            pen_reg.dim          <= 1'b0;
            pen_reg.underline    <= 1'b0;
            pen_reg.inverse      <= 1'b0;
            pen_reg.foreground   <= sgr_pkg::DEFAULT_COLOUR;
            pen_reg.background   <= sgr_pkg::DEFAULT_COLOUR;
            ctrl_reg.phase       <= sgr_pkg::PH_IDLE;
            ctrl_reg.target_fg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= s_tlast;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                pen_reg  <= pen_next;
                ctrl_reg <= ctrl_next;
            end
            if (s1_fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_param_reg <= s_tdata[PARAM_BITS-1:0];
        end
        if (s1_fire && held_load)
        begin
            held_reg <= s1_param_reg;
        end
        if (s1_fire && s1_last_reg)
        begin
            out_pen_reg <= pen_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (ctrl_reg.phase == sgr_pkg::PH_IDLE))
        else $error("run state not cleared at end of sequence");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_last_reg))
        else $error("result raised without a last transaction");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a pending result");
`endif

endmodule
